// ===== src/erb_pkg.sv =====
// shared types and constants for the expanded roi bounding box block
`default_nettype none

package erb_pkg;

   // fixed point and field widths
   localparam int FRAC_BITS = 4;
   localparam int COORD_W   = 20;
   localparam int DIM_W     = 13;
   localparam int SIZE_W    = COORD_W;
   localparam int EXP_W     = SIZE_W + 2;
   localparam int EDGE_W    = COORD_W + 4;
   localparam int CLIP_W    = EDGE_W + 1;

   // queue depths, powers of two
   localparam int FQ_DEPTH  = 2;
   localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);
   localparam int RQ_DEPTH  = 4;
   localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] corner0_x;
      logic signed [COORD_W-1:0] corner0_y;
      logic signed [COORD_W-1:0] corner1_x;
      logic signed [COORD_W-1:0] corner1_y;
      logic signed [COORD_W-1:0] corner2_x;
      logic signed [COORD_W-1:0] corner2_y;
      logic signed [COORD_W-1:0] corner3_x;
      logic signed [COORD_W-1:0] corner3_y;
      logic                      last_quad;
   } req_type;

   typedef struct packed {
      logic             roi_valid;
      logic [DIM_W-1:0] roi_x;
      logic [DIM_W-1:0] roi_y;
      logic [DIM_W-1:0] roi_width;
      logic [DIM_W-1:0] roi_height;
   } rsp_type;

   // box of one quad, as handed from front to back
   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] max_y;
      logic                      last;
   } quad_type;

   typedef struct packed {
      logic     valid;
      quad_type quad;
   } link_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/erb_front.sv =====
// front end: accepts quads, reduces four corners to a box, short queue to the back end
`default_nettype none

module erb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire erb_pkg::req_type  req_data,
   output erb_pkg::link_type      link,
   input  wire logic              link_ready
);

   erb_pkg::quad_type             quad_in;
   erb_pkg::quad_type             mem_ff [erb_pkg::FQ_DEPTH];
   logic [erb_pkg::FQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [erb_pkg::FQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [erb_pkg::FQ_CNT_W-1:0]  count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;
   logic signed [erb_pkg::COORD_W-1:0] xs [4];
   logic signed [erb_pkg::COORD_W-1:0] ys [4];

   // min and max over the four corners
   always_comb begin
      xs[0] = req_data.corner0_x;
      ys[0] = req_data.corner0_y;
      xs[1] = req_data.corner1_x;
      ys[1] = req_data.corner1_y;
      xs[2] = req_data.corner2_x;
      ys[2] = req_data.corner2_y;
      xs[3] = req_data.corner3_x;
      ys[3] = req_data.corner3_y;
      quad_in.min_x = xs[0];
      quad_in.max_x = xs[0];
      quad_in.min_y = ys[0];
      quad_in.max_y = ys[0];
      quad_in.last  = req_data.last_quad;
      for (int i = 1; i < 4; i++) begin
         if (xs[i] < quad_in.min_x) quad_in.min_x = xs[i];
         if (xs[i] > quad_in.max_x) quad_in.max_x = xs[i];
         if (ys[i] < quad_in.min_y) quad_in.min_y = ys[i];
         if (ys[i] > quad_in.max_y) quad_in.max_y = ys[i];
      end
   end

   // queue control
   always_comb begin
      req_full   = (count_ff == erb_pkg::FQ_CNT_W'(erb_pkg::FQ_DEPTH));
      do_push    = req_push && !req_full;
      link.valid = (count_ff != '0);
      link.quad  = mem_ff[rd_ptr_ff];
      do_pop     = link.valid && link_ready;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) count_in = count_ff + erb_pkg::FQ_CNT_W'(1);
      if (!do_push && do_pop) count_in = count_ff - erb_pkg::FQ_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= quad_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/erb_back.sv =====
// back end: running box, expansion, pixel rounding, clipping and result queue
`default_nettype none

module erb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire erb_pkg::link_type link,
   output logic                   link_ready,
   input  wire erb_pkg::cfg_type  cfg,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output erb_pkg::rsp_type       rsp_data
);

   localparam int CW = erb_pkg::COORD_W;
   localparam int SW = erb_pkg::SIZE_W;
   localparam int XW = erb_pkg::EXP_W;
   localparam int EW = erb_pkg::EDGE_W;
   localparam int KW = erb_pkg::CLIP_W;
   localparam int DW = erb_pkg::DIM_W;
   localparam logic [EW-1:0] ROUND_UP = EW'((1 << erb_pkg::FRAC_BITS) - 1);

   // running state
   logic                 first_ff, first_in;
   logic signed [CW-1:0] run_min_x_ff, run_min_x_in;
   logic signed [CW-1:0] run_max_x_ff, run_max_x_in;
   logic signed [CW-1:0] run_min_y_ff, run_min_y_in;
   logic signed [CW-1:0] run_max_y_ff, run_max_y_in;
   logic [SW-1:0]        big_w_ff, big_w_in;
   logic [SW-1:0]        big_h_ff, big_h_in;
   logic [SW-1:0]        big_w_next, big_h_next;
   logic signed [CW:0]   quad_w, quad_h;
   logic                 take;

   // finish stage: merged box of the run
   logic                 fin_v_ff, fin_v_in;
   logic signed [CW-1:0] fin_min_x_ff, fin_max_x_ff, fin_min_y_ff, fin_max_y_ff;
   logic [SW-1:0]        fin_w_ff, fin_h_ff;

   // edge stage: pixel edges before clipping
   logic                 edge_v_ff, edge_v_in;
   logic signed [EW-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic signed [EW-1:0] left_in, right_in, top_in, bottom_in;
   logic [XW-1:0]        exp_w, exp_h;

   // clipping
   logic signed [EW-1:0] x0, y0, x1, y1, img_w, img_h;
   logic signed [KW-1:0] clip_w, clip_h;
   erb_pkg::rsp_type     rsp_in;

   // result queue
   erb_pkg::rsp_type             rq_mem_ff [erb_pkg::RQ_DEPTH];
   logic [erb_pkg::RQ_PTR_W-1:0] rq_wr_ff, rq_wr_in, rq_rd_ff, rq_rd_in;
   logic [erb_pkg::RQ_CNT_W-1:0] rq_count_ff, rq_count_in;
   logic [erb_pkg::RQ_CNT_W:0]   committed;
   logic                         rq_push, rq_pop;

   // a last quad is taken only when the result queue has room for all in flight
   always_comb begin
      committed = (erb_pkg::RQ_CNT_W + 1)'(rq_count_ff)
                + (erb_pkg::RQ_CNT_W + 1)'(fin_v_ff)
                + (erb_pkg::RQ_CNT_W + 1)'(edge_v_ff);
      link_ready = !link.quad.last
                || (committed < (erb_pkg::RQ_CNT_W + 1)'(erb_pkg::RQ_DEPTH));
      take = link.valid && link_ready;
   end

   // merge the quad into the running box
   always_comb begin
      quad_w = $signed({link.quad.max_x[CW-1], link.quad.max_x})
             - $signed({link.quad.min_x[CW-1], link.quad.min_x});
      quad_h = $signed({link.quad.max_y[CW-1], link.quad.max_y})
             - $signed({link.quad.min_y[CW-1], link.quad.min_y});
      big_w_next = (quad_w[SW-1:0] > big_w_ff) ? quad_w[SW-1:0] : big_w_ff;
      big_h_next = (quad_h[SW-1:0] > big_h_ff) ? quad_h[SW-1:0] : big_h_ff;
      if (first_ff) begin
         run_min_x_in = link.quad.min_x;
         run_max_x_in = link.quad.max_x;
         run_min_y_in = link.quad.min_y;
         run_max_y_in = link.quad.max_y;
      end else begin
         run_min_x_in = (link.quad.min_x < run_min_x_ff) ? link.quad.min_x : run_min_x_ff;
         run_max_x_in = (link.quad.max_x > run_max_x_ff) ? link.quad.max_x : run_max_x_ff;
         run_min_y_in = (link.quad.min_y < run_min_y_ff) ? link.quad.min_y : run_min_y_ff;
         run_max_y_in = (link.quad.max_y > run_max_y_ff) ? link.quad.max_y : run_max_y_ff;
      end
      first_in = first_ff;
      big_w_in = big_w_ff;
      big_h_in = big_h_ff;
      if (take) begin
         first_in = link.quad.last;
         big_w_in = link.quad.last ? '0 : big_w_next;
         big_h_in = link.quad.last ? '0 : big_h_next;
      end
      fin_v_in = take && link.quad.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         run_min_x_ff <= '0;
         run_max_x_ff <= '0;
         run_min_y_ff <= '0;
         run_max_y_ff <= '0;
         big_w_ff     <= '0;
         big_h_ff     <= '0;
         fin_v_ff     <= 1'b0;
      end else begin
         first_ff <= first_in;
         big_w_ff <= big_w_in;
         big_h_ff <= big_h_in;
         fin_v_ff <= fin_v_in;
         if (take) begin
            run_min_x_ff <= run_min_x_in;
            run_max_x_ff <= run_max_x_in;
            run_min_y_ff <= run_min_y_in;
            run_max_y_ff <= run_max_y_in;
         end
      end
   end

   // finish stage payload
   always_ff @(posedge clock) begin
      if (fin_v_in) begin
         fin_min_x_ff <= run_min_x_in;
         fin_max_x_ff <= run_max_x_in;
         fin_min_y_ff <= run_min_y_in;
         fin_max_y_ff <= run_max_y_in;
         fin_w_ff     <= big_w_next;
         fin_h_ff     <= big_h_next;
      end
   end

   // expand by four sizes, floor left/top, ceil right/bottom
   always_comb begin
      exp_w = {fin_w_ff, 2'b00};
      exp_h = {fin_h_ff, 2'b00};
      left_in   = ($signed({{(EW-CW){fin_min_x_ff[CW-1]}}, fin_min_x_ff})
                - $signed({{(EW-XW){1'b0}}, exp_w})) >>> erb_pkg::FRAC_BITS;
      top_in    = ($signed({{(EW-CW){fin_min_y_ff[CW-1]}}, fin_min_y_ff})
                - $signed({{(EW-XW){1'b0}}, exp_h})) >>> erb_pkg::FRAC_BITS;
      right_in  = ($signed({{(EW-CW){fin_max_x_ff[CW-1]}}, fin_max_x_ff})
                + $signed({{(EW-XW){1'b0}}, exp_w}) + $signed(ROUND_UP))
                >>> erb_pkg::FRAC_BITS;
      bottom_in = ($signed({{(EW-CW){fin_max_y_ff[CW-1]}}, fin_max_y_ff})
                + $signed({{(EW-XW){1'b0}}, exp_h}) + $signed(ROUND_UP))
                >>> erb_pkg::FRAC_BITS;
      edge_v_in = fin_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_v_ff <= 1'b0;
      end else begin
         edge_v_ff <= edge_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_v_ff) begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
      end
   end

   // intersect with the image rectangle
   always_comb begin
      img_w  = $signed({{(EW-DW){1'b0}}, cfg.image_width});
      img_h  = $signed({{(EW-DW){1'b0}}, cfg.image_height});
      x0     = left_ff[EW-1] ? '0 : left_ff;
      y0     = top_ff[EW-1] ? '0 : top_ff;
      x1     = (right_ff < img_w) ? right_ff : img_w;
      y1     = (bottom_ff < img_h) ? bottom_ff : img_h;
      clip_w = $signed({x1[EW-1], x1}) - $signed({x0[EW-1], x0});
      clip_h = $signed({y1[EW-1], y1}) - $signed({y0[EW-1], y0});
      if ((clip_w > 0) && (clip_h > 0)) begin
         rsp_in.roi_valid  = 1'b1;
         rsp_in.roi_x      = x0[DW-1:0];
         rsp_in.roi_y      = y0[DW-1:0];
         rsp_in.roi_width  = clip_w[DW-1:0];
         rsp_in.roi_height = clip_h[DW-1:0];
      end else begin
         rsp_in = '0;
      end
   end

   // result queue control
   always_comb begin
      rsp_empty = (rq_count_ff == '0);
      rsp_data  = rq_mem_ff[rq_rd_ff];
      rq_push   = edge_v_ff;
      rq_pop    = rsp_pop && !rsp_empty;
      rq_wr_in  = rq_push ? rq_wr_ff + erb_pkg::RQ_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = rq_pop ? rq_rd_ff + erb_pkg::RQ_PTR_W'(1) : rq_rd_ff;
      rq_count_in = rq_count_ff;
      if (rq_push && !rq_pop) rq_count_in = rq_count_ff + erb_pkg::RQ_CNT_W'(1);
      if (!rq_push && rq_pop) rq_count_in = rq_count_ff - erb_pkg::RQ_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_mem_ff[rq_wr_ff] <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/expanded_roi_bounding_box_core.sv =====
// top level of the expanded roi bounding box block: config registers and the two halves
// accepts one quad request per cycle while req_full is low; an accepted request is written
// into the front queue and leaves it when the back end takes it, and its result is registered
// in turn through the two-entry front queue, the finish and edge stages and the four-entry
// result queue before it reaches the result ports; a last quad is held back only while
// queued and in-flight results would fill that queue; synchronous reset empties both
// queues and clears the run and the image size registers
`default_nettype none

module expanded_roi_bounding_box_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire erb_pkg::req_type                req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output erb_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [erb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [erb_pkg::DIM_W-1:0]       csr_wdata
);

   erb_pkg::cfg_type  cfg_ff, cfg_in;
   erb_pkg::link_type link;
   logic              link_ready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            erb_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata;
            end
            erb_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   erb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .link       (link),
      .link_ready (link_ready)
   );

   erb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .link       (link),
      .link_ready (link_ready),
      .cfg        (cfg_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/expanded_roi_bounding_box_core_tb.sv =====
// testbench for the expanded roi bounding box core: directed and random quad runs
`timescale 1ns / 1ps

module expanded_roi_bounding_box_core_tb;

   localparam int EXPAND_SCALE = 4;
   localparam int DRAIN_PAD    = 8;
   localparam int COORD_MAX    = 524287;
   localparam int COORD_MIN    = -524288;

   logic                          clock;
   logic                          reset;
   logic                          req_push;
   logic                          req_full;
   erb_pkg::req_type              req_data;
   logic                          rsp_empty;
   logic                          rsp_pop;
   erb_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [erb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [erb_pkg::DIM_W-1:0]     csr_wdata;

   // predictor state: image size and the open run
   longint img_w, img_h;
   int     run_lo_x, run_hi_x, run_lo_y, run_hi_y;
   longint widest_quad, tallest_quad;
   bit     run_fresh;

   erb_pkg::rsp_type roi_expected[$];

   int  quads_sent, regions_checked, empty_regions, size_settings, errors;
   bit  steady;

   expanded_roi_bounding_box_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint px_floor(longint v);
      return v >>> erb_pkg::FRAC_BITS;
   endfunction

   function automatic logic [erb_pkg::COORD_W-1:0] to_coord(int v);
      if (v > COORD_MAX) return erb_pkg::COORD_W'(COORD_MAX);
      if (v < COORD_MIN) return erb_pkg::COORD_W'(COORD_MIN);
      return erb_pkg::COORD_W'(v);
   endfunction

   function automatic erb_pkg::req_type quad_from_points(int x0, int y0, int x1, int y1,
                                                         int x2, int y2, int x3, int y3,
                                                         bit last);
      erb_pkg::req_type q;
      q.corner0_x = to_coord(x0);
      q.corner0_y = to_coord(y0);
      q.corner1_x = to_coord(x1);
      q.corner1_y = to_coord(y1);
      q.corner2_x = to_coord(x2);
      q.corner2_y = to_coord(y2);
      q.corner3_x = to_coord(x3);
      q.corner3_y = to_coord(y3);
      q.last_quad = last;
      return q;
   endfunction

   function automatic erb_pkg::req_type point_quad(int x, int y, bit last);
      return quad_from_points(x, y, x, y, x, y, x, y, last);
   endfunction

   // running box update, and on the last quad the expanded and clipped region
   task automatic predict_roi(input erb_pkg::req_type q);
      int               xs[4], ys[4];
      int               lo_x, hi_x, lo_y, hi_y;
      longint           left, right, top, bottom, x0, y0, x1, y1;
      erb_pkg::rsp_type r;
      xs[0] = q.corner0_x;
      ys[0] = q.corner0_y;
      xs[1] = q.corner1_x;
      ys[1] = q.corner1_y;
      xs[2] = q.corner2_x;
      ys[2] = q.corner2_y;
      xs[3] = q.corner3_x;
      ys[3] = q.corner3_y;
      lo_x = xs[0];
      hi_x = xs[0];
      lo_y = ys[0];
      hi_y = ys[0];
      for (int i = 1; i < 4; i++) begin
         if (xs[i] < lo_x) lo_x = xs[i];
         if (xs[i] > hi_x) hi_x = xs[i];
         if (ys[i] < lo_y) lo_y = ys[i];
         if (ys[i] > hi_y) hi_y = ys[i];
      end
      // first quad of a run loads the box, later ones widen it
      if (run_fresh) begin
         run_lo_x  = lo_x;
         run_hi_x  = hi_x;
         run_lo_y  = lo_y;
         run_hi_y  = hi_y;
         run_fresh = 1'b0;
      end else begin
         if (lo_x < run_lo_x) run_lo_x = lo_x;
         if (hi_x > run_hi_x) run_hi_x = hi_x;
         if (lo_y < run_lo_y) run_lo_y = lo_y;
         if (hi_y > run_hi_y) run_hi_y = hi_y;
      end
      if (longint'(hi_x) - lo_x > widest_quad) widest_quad = longint'(hi_x) - lo_x;
      if (longint'(hi_y) - lo_y > tallest_quad) tallest_quad = longint'(hi_y) - lo_y;
      if (!q.last_quad) return;
      // expand, round outward to whole pixels, clip to the image
      left   = px_floor(longint'(run_lo_x) - EXPAND_SCALE * widest_quad);
      right  = -px_floor(-(longint'(run_hi_x) + EXPAND_SCALE * widest_quad));
      top    = px_floor(longint'(run_lo_y) - EXPAND_SCALE * tallest_quad);
      bottom = -px_floor(-(longint'(run_hi_y) + EXPAND_SCALE * tallest_quad));
      x0 = (left > 0) ? left : 0;
      y0 = (top > 0) ? top : 0;
      x1 = (right < img_w) ? right : img_w;
      y1 = (bottom < img_h) ? bottom : img_h;
      if (x1 - x0 <= 0 || y1 - y0 <= 0) begin
         r = '0;
      end else begin
         r.roi_valid  = 1'b1;
         r.roi_x      = erb_pkg::DIM_W'(x0);
         r.roi_y      = erb_pkg::DIM_W'(y0);
         r.roi_width  = erb_pkg::DIM_W'(x1 - x0);
         r.roi_height = erb_pkg::DIM_W'(y1 - y0);
      end
      roi_expected.push_back(r);
      run_fresh    = 1'b1;
      widest_quad  = 0;
      tallest_quad = 0;
   endtask

   // one quad request, held until taken, then an optional gap
   task automatic send_quad(input erb_pkg::req_type q);
      int gap;
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_full);
      predict_roi(q);
      quads_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and wait for every region to come back
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (roi_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_csr(input logic [erb_pkg::CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= erb_pkg::DIM_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == erb_pkg::CSR_IMAGE_WIDTH) img_w = val;
      else img_h = val;
   endtask

   task automatic set_image_size(input int w, input int h);
      write_csr(erb_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(erb_pkg::CSR_IMAGE_HEIGHT, h);
      size_settings++;
   endtask

   // random quad: mostly near the image, some fully random, some at range limits
   function automatic erb_pkg::req_type random_quad(bit last);
      int kind, cx, cy, ext;
      int xs[4], ys[4];
      int rails[4];
      erb_pkg::req_type q;
      rails = '{COORD_MIN, COORD_MAX, 0, -1};
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         cx  = int'($urandom_range(0, (int'(img_w) + 80) * 16)) - 640;
         cy  = int'($urandom_range(0, (int'(img_h) + 80) * 16)) - 640;
         ext = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 256);
         for (int i = 0; i < 4; i++) begin
            xs[i] = cx + int'($urandom_range(0, 2 * ext)) - ext;
            ys[i] = cy + int'($urandom_range(0, 2 * ext)) - ext;
         end
         q = quad_from_points(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3], last);
      end else if (kind < 90) begin
         q.corner0_x = erb_pkg::COORD_W'($urandom);
         q.corner0_y = erb_pkg::COORD_W'($urandom);
         q.corner1_x = erb_pkg::COORD_W'($urandom);
         q.corner1_y = erb_pkg::COORD_W'($urandom);
         q.corner2_x = erb_pkg::COORD_W'($urandom);
         q.corner2_y = erb_pkg::COORD_W'($urandom);
         q.corner3_x = erb_pkg::COORD_W'($urandom);
         q.corner3_y = erb_pkg::COORD_W'($urandom);
         q.last_quad = last;
      end else begin
         for (int i = 0; i < 4; i++) begin
            xs[i] = rails[$urandom_range(0, 3)];
            ys[i] = rails[$urandom_range(0, 3)];
         end
         q = quad_from_points(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3], last);
      end
      return q;
   endfunction

   // image size still at its reset value: every region is empty
   task automatic test_reset_size();
      send_quad(quad_from_points(160, 160, 320, 160, 320, 320, 160, 320, 1'b1));
   endtask

   task automatic test_directed_boxes();
      settle();
      set_image_size(8191, 8191);
      send_quad(point_quad(0, 0, 1'b1));
      // corners at the range limits, clipped to the whole image
      send_quad(quad_from_points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                                 COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1));
      // a lone point right after a huge run: box reloads, sizes cleared
      send_quad(point_quad(16003, 32009, 1'b1));
      // negative fraction rounds outward to an empty box
      send_quad(point_quad(-5, -5, 1'b1));
      // three-quad run, the extremes coming from different corners
      send_quad(quad_from_points(100, 500, 300, 200, 700, 400, 400, 900, 1'b0));
      send_quad(quad_from_points(600, 800, 90, 700, 650, 150, 680, 910, 1'b0));
      send_quad(quad_from_points(5000, 300, 4000, 250, 4500, 400, 4200, 350, 1'b1));
      // point at the top of the range lies past the image
      send_quad(point_quad(COORD_MAX, COORD_MAX, 1'b1));
      // small far quad merged into a run with a larger first quad
      send_quad(quad_from_points(1600, 1600, 3200, 1600, 3200, 3200, 1600, 3200, 1'b0));
      send_quad(quad_from_points(40000, 48000, 40016, 48000, 40016, 48016, 40000, 48016, 1'b1));
   endtask

   task automatic test_clip_edges();
      settle();
      set_image_size(1, 1);
      send_quad(point_quad(0, 0, 1'b1));
      send_quad(point_quad(1, 1, 1'b1));
      settle();
      set_image_size(0, 8191);
      send_quad(quad_from_points(160, 160, 320, 160, 320, 320, 160, 320, 1'b1));
      settle();
      set_image_size(8191, 0);
      send_quad(quad_from_points(160, 160, 320, 160, 320, 320, 160, 320, 1'b1));
      settle();
      set_image_size(640, 480);
      // box running over the right and bottom edges
      send_quad(quad_from_points(10000, 7600, 10300, 7600, 10300, 7700, 10000, 7700, 1'b1));
      // box wholly above and left of the image
      send_quad(point_quad(-100000, -100000, 1'b1));
   endtask

   // random runs of random length under one image size
   task automatic test_random_runs(input int w, input int h, input int count, input bit quiet);
      int sent, run_len;
      settle();
      set_image_size(w, h);
      steady = quiet;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               run_len = $urandom_range(1, 4);
            end
            6, 7, 8: begin
               run_len = $urandom_range(5, 12);
            end
            default: begin
               run_len = $urandom_range(13, 40);
            end
         endcase
         for (int k = 0; k < run_len; k++) begin
            send_quad(random_quad(k == run_len - 1));
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   // result side: random stalls on pop
   int pop_hold = 0;
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop <= 1'b0;
         pop_hold--;
      end else begin
         rsp_pop <= 1'b1;
         pop_hold = pick_gap();
      end
   end

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("roi %s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // compare each popped region with the oldest prediction
   always @(posedge clock) begin : check_regions
      erb_pkg::rsp_type want;
      if (!reset && !rsp_empty && rsp_pop) begin
         if (roi_expected.size() == 0) begin
            $error("region popped with none predicted");
            errors++;
         end else begin
            want = roi_expected.pop_front();
            check_field("roi_valid", want.roi_valid, rsp_data.roi_valid);
            check_field("roi_x", want.roi_x, rsp_data.roi_x);
            check_field("roi_y", want.roi_y, rsp_data.roi_y);
            check_field("roi_width", want.roi_width, rsp_data.roi_width);
            check_field("roi_height", want.roi_height, rsp_data.roi_height);
            regions_checked++;
            if (!want.roi_valid) empty_regions++;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("expanded_roi_bounding_box_core verification failed");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_push     = 1'b0;
      req_data     = '0;
      rsp_pop      = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      img_w        = 0;
      img_h        = 0;
      run_lo_x     = 0;
      run_hi_x     = 0;
      run_lo_y     = 0;
      run_hi_y     = 0;
      widest_quad  = 0;
      tallest_quad = 0;
      run_fresh    = 1'b1;
      steady       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_directed_boxes();
      test_clip_edges();
      test_random_runs(8191, 8191, 250, 1'b0);
      test_random_runs(640, 480, 250, 1'b0);
      test_random_runs(1920, 1080, 250, 1'b1);
      test_random_runs(1, 1, 150, 1'b0);
      test_random_runs($urandom_range(0, 8191), $urandom_range(0, 8191), 250, 1'b0);
      test_random_runs(0, 100, 100, 1'b0);
      test_random_runs(8191, 1, 100, 1'b0);
      test_random_runs($urandom_range(1, 8191), $urandom_range(1, 8191), 400, 1'b0);
      settle();

      $display("%0d quads sent under %0d image sizes", quads_sent, size_settings);
      $display("%0d regions checked, %0d of them empty", regions_checked, empty_regions);
      if (errors == 0) begin
         $display("expanded_roi_bounding_box_core verification clean");
      end else begin
         $display("expanded_roi_bounding_box_core verification failed");
      end
      $finish;
   end

endmodule
